FILE: rtl/wrip_pkg.sv
// Shared types and constants for the weighted random index picker.
// Holds opcodes, status codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package wrip_pkg;

  localparam int unsigned SUM_W    = 24;
  localparam int unsigned RAND_W   = 31;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned DCNT_W   = 5;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CNT_W    = 9;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [DCNT_W-1:0] DIV_LAST_BIT = DCNT_W'(RAND_W - 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PICK   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic nop;
    logic pick_empty;
    logic div_load;
    logic div_step;
    logic scan_step;
    logic pick_hit;
    logic pick_miss;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic div_last;
    logic hit;
    logic scan_end;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/wrip_ctrl.sv
// Sequencer for the weighted random index picker.
// Decodes commands and steps the datapath through divide and scan; uses wrip_pkg.
`default_nettype none

module wrip_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic [1:0]      opcode_i,
  input  wrip_pkg::stat_t      stat_i,
  output wrip_pkg::cmd_t       cmd_o,
  output logic                 busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (opcode_i)
            wrip_pkg::OP_CLEAR:  cmd_o.clear = 1'b1;
            wrip_pkg::OP_APPEND: cmd_o.append = 1'b1;
            wrip_pkg::OP_PICK: begin
              if (stat_i.empty) begin
                cmd_o.pick_empty = 1'b1;
              end else begin
                cmd_o.div_load = 1'b1;
                state_d        = S_DIV;
              end
            end
            default: cmd_o.nop = 1'b1;
          endcase
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.hit) begin
          cmd_o.pick_hit = 1'b1;
          state_d        = S_IDLE;
        end else if (stat_i.scan_end) begin
          cmd_o.pick_miss = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The last divide step always hands over to the scan.
  a_div_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && stat_i.div_last) |=> state_q == S_SCAN)
    else $error("divide did not hand over to scan");

  // A pick that leaves the idle state was not on an empty table.
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |-> !stat_i.empty)
    else $error("divide started on empty table");

endmodule

`default_nettype wire

FILE: rtl/wrip_datapath.sv
// Datapath for the weighted random index picker: sum table memory, running total,
// serial remainder unit, scan pointer and result registers. Uses wrip_pkg.
`default_nettype none

module wrip_datapath #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wrip_pkg::cmd_t                     cmd_i,
  input  wire logic [wrip_pkg::WIN_W-1:0]    weight_i,
  input  wire logic [wrip_pkg::RAND_W-1:0]   random_value_i,
  output wrip_pkg::stat_t                    stat_o,
  output logic                               done_o,
  output logic [wrip_pkg::IDX_W-1:0]         picked_index_o,
  output logic [1:0]                         status_o,
  output logic [wrip_pkg::CNT_W-1:0]         entry_count_o
);

  localparam int unsigned SW  = wrip_pkg::SUM_W;
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned IWW = (AW > wrip_pkg::IDX_W) ? AW : wrip_pkg::IDX_W;
  localparam int unsigned CWW = (CW > wrip_pkg::CNT_W) ? CW : wrip_pkg::CNT_W;
  localparam logic [wrip_pkg::WIN_W-1:0] WMASK =
    wrip_pkg::WIN_W'((33'd1 << WEIGHT_BITS) - 33'd1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  logic [SW-1:0] mem [MAX_ENTRIES];

  logic [CW-1:0]                   count_q, count_d;
  logic [SW-1:0]                   total_q, total_d;
  logic [SW:0]                     sum_wide;
  logic                            full;

  logic [wrip_pkg::RAND_W-1:0]     rnd_q;
  logic [SW-1:0]                   rem_q;
  logic [wrip_pkg::DCNT_W-1:0]     bit_q;
  logic [SW:0]                     trial;
  logic [SW:0]                     ticket;

  logic [CW-1:0]                   ptr_q;
  logic                            rd_en;
  logic                            rd_vld_q;
  logic [AW-1:0]                   rd_idx_q;
  logic [SW-1:0]                   rd_data_q;

  logic                            res_vld_q;
  logic [AW-1:0]                   res_idx_q;
  wrip_pkg::status_e               res_status_q;
  logic [IWW-1:0]                  idx_wide;
  logic [CWW-1:0]                  cnt_wide;

  assign full     = (count_q == CNT_MAX);
  assign sum_wide = {1'b0, total_q} + (SW + 1)'(weight_i & WMASK);

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.clear) begin
      count_d = '0;
      total_d = '0;
    end else if (cmd_i.append && !full) begin
      count_d = count_q + CW'(1);
      total_d = sum_wide[SW] ? wrip_pkg::SUM_MAX : sum_wide[SW-1:0];
    end
  end

  // Restoring remainder step: remainder stays below the total.
  assign trial  = {rem_q, rnd_q[wrip_pkg::RAND_W-1]};
  assign ticket = {1'b0, rem_q} + (SW + 1)'(1);
  assign rd_en  = cmd_i.scan_step && (ptr_q < count_q);

  assign stat_o.empty    = (count_q == '0) || (total_q == '0);
  assign stat_o.div_last = (bit_q == '0);
  assign stat_o.hit      = rd_vld_q && ({1'b0, rd_data_q} >= ticket);
  assign stat_o.scan_end = rd_vld_q && ((CW'(rd_idx_q) + CW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      total_q   <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      total_q   <= total_d;
      rd_vld_q  <= rd_en;
      res_vld_q <= cmd_i.clear | cmd_i.append | cmd_i.nop | cmd_i.pick_empty |
                   cmd_i.pick_hit | cmd_i.pick_miss;
    end
  end

  // Table write and registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[count_q[AW-1:0]] <= total_d;
    end
    if (rd_en) begin
      rd_data_q <= mem[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rnd_q <= random_value_i;
      rem_q <= '0;
      bit_q <= wrip_pkg::DIV_LAST_BIT;
      ptr_q <= '0;
    end else begin
      if (cmd_i.div_step) begin
        rnd_q <= {rnd_q[wrip_pkg::RAND_W-2:0], 1'b0};
        bit_q <= bit_q - wrip_pkg::DCNT_W'(1);
        if (trial >= {1'b0, total_q}) begin
          rem_q <= SW'(trial - {1'b0, total_q});
        end else begin
          rem_q <= trial[SW-1:0];
        end
      end
      if (rd_en) begin
        ptr_q    <= ptr_q + CW'(1);
        rd_idx_q <= ptr_q[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q    <= '0;
    res_status_q <= wrip_pkg::ST_OK;
    if (cmd_i.append && full) begin
      res_status_q <= wrip_pkg::ST_FULL;
    end else if (cmd_i.pick_empty || cmd_i.pick_miss) begin
      res_status_q <= wrip_pkg::ST_EMPTY;
    end else if (cmd_i.pick_hit) begin
      res_idx_q <= rd_idx_q;
    end
  end

  assign idx_wide       = IWW'(res_idx_q);
  assign cnt_wide       = CWW'(count_q);
  assign done_o         = res_vld_q;
  assign picked_index_o = idx_wide[wrip_pkg::IDX_W-1:0];
  assign status_o       = res_status_q;
  assign entry_count_o  = cnt_wide[wrip_pkg::CNT_W-1:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count above table depth");

  // Only stored entries are ever read back.
  a_read_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (CW'(rd_idx_q) < count_q))
    else $error("scan read beyond stored entries");

endmodule

`default_nettype wire

FILE: rtl/weighted_random_index_picker.sv
// Top level of the weighted random index picker.
// Instantiates wrip_ctrl and wrip_datapath; uses wrip_pkg.
`default_nettype none

// A command transfers on a rising edge with start high and busy low. Clear,
// append and the unused opcode finish in the accepting cycle: the result shows
// on the next cycle with done_o, and busy stays low, so such commands may be
// issued every cycle. A pick on a non-empty table raises busy for a serial
// remainder (one random bit per cycle) followed by a scan of the sum table
// that reads one entry per cycle from a single-port memory; the result of a
// pick shows in the same cycle that busy falls. Each result is on the outputs
// for exactly one cycle under done_o and the receiver cannot stall it;
// results come in command order.
// entry_count_o reports the number of stored weights after the command.
module weighted_random_index_picker #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [wrip_pkg::WIN_W-1:0]    weight_i,
  input  wire logic [wrip_pkg::RAND_W-1:0]   random_value_i,
  output logic                               done_o,
  output logic [wrip_pkg::IDX_W-1:0]         picked_index_o,
  output logic [1:0]                         status_o,
  output logic [wrip_pkg::CNT_W-1:0]         entry_count_o
);

  wrip_pkg::cmd_t  cmd;
  wrip_pkg::stat_t stat;

  // Sequence commands: decode, divide, scan.
  wrip_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Hold the table, total, remainder unit and result registers.
  wrip_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .weight_i       (weight_i),
    .random_value_i (random_value_i),
    .stat_o         (stat),
    .done_o         (done_o),
    .picked_index_o (picked_index_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  // Every accepted command either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither answered nor in progress");

  // A result never shows while a pick is still running.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !done_o)
    else $error("result strobe during a running pick");

endmodule

`default_nettype wire

FILE: bench/weighted_random_index_picker_tb.sv
// Self-checking testbench for weighted_random_index_picker.
// Drives clear/append/pick commands and checks every result against a local predictor or a typed-in expected value.
// Depends on wrip_pkg and weighted_random_index_picker.
`timescale 1ns / 1ps

module weighted_random_index_picker_tb;

  localparam int unsigned MAX_ENTRIES    = 256;
  localparam int unsigned WEIGHT_BITS    = 16;
  localparam int          RANDOM_ITEMS   = 1950;
  // Longest correct silence: a long sender gap plus a pick that scans
  // the whole table; allow many times that.
  localparam int          WATCHDOG_LIMIT = 4000;
  // After the last result, keep watching longer than one full-table pick.
  localparam int          TAIL_CYCLES    = 320;
  localparam int          N_DIRECTED     = 20;

  // The fourth opcode has no package name: the block treats it as a no-op.
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [30:0] RAND_ALL  = 31'h7FFF_FFFF;
  // Only the low WEIGHT_BITS bits of a weight count.
  localparam logic [15:0] WEIGHT_MASK = 16'((33'd1 << WEIGHT_BITS) - 33'd1);

  typedef struct packed {
    logic [7:0] idx;
    logic [1:0] status;
    logic [8:0] count;
  } pick_res_t;

  // One command transfer, optionally with a hand-written expected result.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] weight;
    logic [30:0] rnd;
    logic        has_exp;
    pick_res_t   exp;
  } cmd_row_t;

  localparam pick_res_t NO_EXP = '0;

  // Directed commands. Expected results are typed in where they follow
  // directly from the table contents; the rest go through the predictor.
  localparam cmd_row_t DIR_ROWS [N_DIRECTED] = '{
    // pick right after reset: empty table
    '{wrip_pkg::OP_PICK,   16'h0000, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_EMPTY, 9'd0}},
    // zero weight: table holds one entry but the total stays zero
    '{wrip_pkg::OP_APPEND, 16'h0000, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd1}},
    '{wrip_pkg::OP_PICK,   16'h0000, RAND_ALL,     1'b1, '{8'd0, wrip_pkg::ST_EMPTY, 9'd1}},
    // unused opcode with every payload bit set changes nothing
    '{OP_UNUSED,           16'hFFFF, RAND_ALL,     1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd1}},
    '{wrip_pkg::OP_APPEND, 16'hFFFF, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd2}},
    // ticket 1 must skip the zero-weight entry
    '{wrip_pkg::OP_PICK,   16'h0000, 31'd0,        1'b1, '{8'd1, wrip_pkg::ST_OK,    9'd2}},
    '{wrip_pkg::OP_PICK,   16'hFFFF, RAND_ALL,     1'b0, NO_EXP},
    '{wrip_pkg::OP_APPEND, 16'h0001, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd3}},
    // tickets at the top of the total and just below the last boundary
    '{wrip_pkg::OP_PICK,   16'h0000, 31'd65535,    1'b1, '{8'd2, wrip_pkg::ST_OK,    9'd3}},
    '{wrip_pkg::OP_PICK,   16'h0000, 31'd65534,    1'b1, '{8'd1, wrip_pkg::ST_OK,    9'd3}},
    '{wrip_pkg::OP_CLEAR,  16'hFFFF, RAND_ALL,     1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd0}},
    '{wrip_pkg::OP_PICK,   16'h0000, 31'd5,        1'b1, '{8'd0, wrip_pkg::ST_EMPTY, 9'd0}},
    '{wrip_pkg::OP_APPEND, 16'hAAAA, 31'd0,        1'b0, NO_EXP},
    '{wrip_pkg::OP_APPEND, 16'h5555, 31'd0,        1'b0, NO_EXP},
    '{wrip_pkg::OP_PICK,   16'h5555, 31'h2AAAAAAA, 1'b0, NO_EXP},
    '{wrip_pkg::OP_PICK,   16'hAAAA, 31'h55555555, 1'b0, NO_EXP},
    '{wrip_pkg::OP_CLEAR,  16'h0000, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd0}},
    '{wrip_pkg::OP_APPEND, 16'h0001, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd1}},
    // total of one: any random value lands on entry zero
    '{wrip_pkg::OP_PICK,   16'h0000, RAND_ALL,     1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd1}},
    '{OP_UNUSED,           16'h0000, 31'd0,        1'b1, '{8'd0, wrip_pkg::ST_OK,    9'd1}}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [1:0]                   opcode_i;
  logic [wrip_pkg::WIN_W-1:0]   weight_i;
  logic [wrip_pkg::RAND_W-1:0]  random_value_i;
  logic                         done_o;
  logic [wrip_pkg::IDX_W-1:0]   picked_index_o;
  logic [1:0]                   status_o;
  logic [wrip_pkg::CNT_W-1:0]   entry_count_o;

  weighted_random_index_picker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .weight_i      (weight_i),
    .random_value_i(random_value_i),
    .done_o        (done_o),
    .picked_index_o(picked_index_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  // Predictor copy of the prefix-sum table.
  logic [23:0]  sum_tab [MAX_ENTRIES];
  int unsigned  tab_count;
  logic [23:0]  tab_total;

  cmd_row_t     cmd_list [$];
  pick_res_t    pending_results [$];

  int           next_cmd;
  bit           in_flight;
  int           gap_left;
  int           burst_left;
  int           idle_cycles;
  int           tail_cycles;
  int           n_errors;
  int           n_results;
  bit           run_over;
  bit           timed_out;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the predicted table by one command and return its result.
  task automatic apply_command(input cmd_row_t c, output pick_res_t r);
    logic [24:0] sum_ext;
    logic [31:0] ticket;
    bit          found;
    int          k;
    r = '0;
    case (c.op)
      wrip_pkg::OP_CLEAR: begin
        tab_count = 0;
        tab_total = '0;
      end
      wrip_pkg::OP_APPEND: begin
        if (tab_count >= MAX_ENTRIES) begin
          r.status = wrip_pkg::ST_FULL;
        end else begin
          // saturate the running total at the sum width
          sum_ext   = {1'b0, tab_total} + 25'(c.weight & WEIGHT_MASK);
          tab_total = sum_ext[24] ? wrip_pkg::SUM_MAX : sum_ext[23:0];
          sum_tab[tab_count] = tab_total;
          tab_count++;
        end
      end
      wrip_pkg::OP_PICK: begin
        if (tab_count == 0 || tab_total == '0) begin
          r.status = wrip_pkg::ST_EMPTY;
        end else begin
          ticket = {1'b0, c.rnd} % {8'd0, tab_total} + 32'd1;
          found  = 1'b0;
          for (k = 0; k < int'(tab_count); k++) begin
            if (!found && ticket <= {8'd0, sum_tab[k]}) begin
              r.idx = k[7:0];
              found = 1'b1;
            end
          end
          if (!found) r.status = wrip_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
    r.count = tab_count[8:0];
  endtask

  // Most gaps are short, a few long; now and then a run of back-to-back commands.
  function automatic int choose_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_weight(input int mode);
    case (mode)
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, 15));
      // sparse: mostly zero-weight entries between a few heavy ones
      2:       return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
      3:       return 16'd0;
      default: return 16'hFFFF - 16'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [30:0] rand_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 31'd0;
    if (r < 16) return RAND_ALL;
    if (r < 30) return 31'($urandom_range(0, 1000));
    return 31'($urandom());
  endfunction

  function automatic cmd_row_t make_cmd(input logic [1:0] op, input logic [15:0] w,
                                        input logic [30:0] rnd);
    cmd_row_t c;
    c.op      = op;
    c.weight  = w;
    c.rnd     = rnd;
    c.has_exp = 1'b0;
    c.exp     = NO_EXP;
    return c;
  endfunction

  // Build the command list: directed rows, then episodes of
  // clear / fill / pick with some noise mixed in.
  task automatic build_commands();
    bit first_episode;
    int n_app;
    int n_pick;
    int wmode;
    int r;
    int i;
    foreach (DIR_ROWS[j]) cmd_list.push_back(DIR_ROWS[j]);
    first_episode = 1'b1;
    while (cmd_list.size() < N_DIRECTED + RANDOM_ITEMS) begin
      if (first_episode || $urandom_range(0, 99) < 85)
        cmd_list.push_back(make_cmd(wrip_pkg::OP_CLEAR, 16'($urandom()), 31'($urandom())));
      if ($urandom_range(0, 99) < 10)
        cmd_list.push_back(make_cmd(wrip_pkg::OP_PICK, 16'($urandom()), rand_draw()));
      r = $urandom_range(0, 99);
      if (first_episode)  n_app = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 6);
      else if (r < 60)    n_app = $urandom_range(1, 8);
      else if (r < 85)    n_app = $urandom_range(9, 48);
      else if (r < 94)    n_app = $urandom_range(49, 200);
      else                n_app = $urandom_range(MAX_ENTRIES - 6, MAX_ENTRIES + 9);
      wmode = first_episode ? 0 : $urandom_range(0, 4);
      for (i = 0; i < n_app; i++)
        cmd_list.push_back(make_cmd(wrip_pkg::OP_APPEND, rand_weight(wmode),
                                    31'($urandom())));
      n_pick = $urandom_range(1, 24);
      for (i = 0; i < n_pick; i++) begin
        r = $urandom_range(0, 99);
        if (r < 84)
          cmd_list.push_back(make_cmd(wrip_pkg::OP_PICK, 16'($urandom()), rand_draw()));
        else if (r < 90)
          cmd_list.push_back(make_cmd(wrip_pkg::OP_APPEND, rand_weight(wmode),
                                      31'($urandom())));
        else if (r < 95)
          cmd_list.push_back(make_cmd(OP_UNUSED, 16'($urandom()), 31'($urandom())));
        else if (r < 97)
          cmd_list.push_back(make_cmd(wrip_pkg::OP_CLEAR, 16'($urandom()), 31'($urandom())));
        else
          cmd_list.push_back(make_cmd(2'($urandom_range(0, 3)), 16'($urandom()),
                                      rand_draw()));
      end
      first_episode = 1'b0;
    end
  endtask

  // Hold reset with every input at a known value.
  initial begin : reset_seq
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    opcode_i       <= '0;
    weight_i       <= '0;
    random_value_i <= '0;
    tab_count   = 0;
    tab_total   = '0;
    next_cmd    = 0;
    in_flight   = 1'b0;
    gap_left    = 0;
    burst_left  = 0;
    idle_cycles = 0;
    tail_cycles = 0;
    n_errors    = 0;
    n_results   = 0;
    run_over    = 1'b0;
    timed_out   = 1'b0;
    build_commands();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // One process per edge: check the result strobe, note a command transfer,
  // then drive the next command or a gap. All reads see pre-edge values.
  always @(posedge clk_i) begin : drive_and_check
    pick_res_t got_res;
    pick_res_t want_res;
    pick_res_t pred_res;
    bit        moved;
    if (rst_ni && !run_over) begin
      moved = 1'b0;

      // Results cannot be held off: take every strobe as it comes.
      if (done_o) begin
        moved   = 1'b1;
        got_res = '{picked_index_o, status_o, entry_count_o};
        if (pending_results.size() == 0) begin
          if (n_errors < 10)
            $display("%0t: result with no command outstanding: idx=%0d status=%0d count=%0d",
                      $realtime, got_res.idx, got_res.status, got_res.count);
          n_errors++;
        end else begin
          want_res = pending_results.pop_front();
          if (got_res != want_res) begin
            if (n_errors < 10) begin
              $write("%0t: result %0d mismatch: expected idx=%0d status=%0d count=%0d,",
                     $realtime, n_results, want_res.idx, want_res.status, want_res.count);
              $display(" got idx=%0d status=%0d count=%0d",
                       got_res.idx, got_res.status, got_res.count);
            end
            n_errors++;
          end
        end
        n_results++;
      end

      // Command transfer: predict now, in acceptance order.
      if (start && !busy) begin
        moved = 1'b1;
        apply_command(cmd_list[next_cmd], pred_res);
        pending_results.push_back(cmd_list[next_cmd].has_exp ? cmd_list[next_cmd].exp
                                                              : pred_res);
        next_cmd++;
        in_flight = 1'b0;
      end

      // Hold a waiting command; otherwise idle out the gap or present the next one.
      if (in_flight) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (next_cmd < cmd_list.size()) begin
        start          <= 1'b1;
        opcode_i       <= cmd_list[next_cmd].op;
        weight_i       <= cmd_list[next_cmd].weight;
        random_value_i <= cmd_list[next_cmd].rnd;
        in_flight = 1'b1;
        gap_left  = choose_gap();
      end else begin
        start <= 1'b0;
      end

      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding, %0d of %0d commands sent",
                 $realtime, pending_results.size(), next_cmd, cmd_list.size());
        timed_out = 1'b1;
        run_over  = 1'b1;
      end else if (next_cmd == cmd_list.size() && !in_flight &&
                   pending_results.size() == 0) begin
        // drain: keep watching for stray strobes before ending
        tail_cycles++;
        if (tail_cycles >= TAIL_CYCLES) run_over = 1'b1;
      end
    end
  end

  initial begin : finish_run
    wait (run_over);
    if (!timed_out && n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
